// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off while reset is high
`define ASSERT_ON_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/fpba_pkg.sv
package fpba_pkg;

   localparam int KindBits      = 1;
   localparam int IndexBits     = 4;
   localparam int AmountBits    = 16;
   localparam int PolicyBits    = 2;
   localparam int CountBits     = 5;
   localparam int CsrIndexBits  = 4;
   localparam int CsrDataBits   = 5;

   localparam logic [KindBits-1:0] KIND_LOAD    = 1'b0;
   localparam logic [KindBits-1:0] KIND_REQUEST = 1'b1;

   localparam logic [PolicyBits-1:0] POLICY_FIRST = 2'd0;
   localparam logic [PolicyBits-1:0] POLICY_BEST  = 2'd1;
   localparam logic [PolicyBits-1:0] POLICY_WORST = 2'd2;

   localparam logic [CsrIndexBits-1:0] CSR_FIT_POLICY    = 4'd0;
   localparam logic [CsrIndexBits-1:0] CSR_BLOCKS_IN_USE = 4'd1;

   localparam logic [PolicyBits-1:0] POLICY_RESET = POLICY_FIRST;
   localparam logic [CountBits-1:0]  COUNT_RESET  = 5'd16;

   typedef struct packed {
      logic [KindBits-1:0]   kind;
      logic [IndexBits-1:0]  block_index;
      logic [AmountBits-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                  granted;
      logic [IndexBits-1:0]  chosen_block;
      logic [AmountBits-1:0] leftover_size;
   } rsp_type;

endpackage

// File: rtl/fit_policy_block_allocator.sv
// request: result strobe after the launch, cell and result registers; busy until then,
// so new requests wait for the result. the candidate walks the cell row one cell a cycle
// load: taken at accept with no result; loads may follow every cycle while idle
// rsp_valid marks each result for exactly one cycle; the receiver cannot stall
// reset is synchronous: busy while high; clears control, policy and count; block sizes
// stay undefined until loaded
`include "assert_macros.svh"

module fit_policy_block_allocator #(
   parameter int BLOCKS    = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  fpba_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output fpba_pkg::rsp_type                 rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fpba_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [fpba_pkg::CsrDataBits-1:0]  csr_wdata
);

   localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int SW = SIZE_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                            state_ff;
   logic                            launch_ff;
   logic [SW-1:0]                   amount_ff;
   logic [fpba_pkg::PolicyBits-1:0] policy_ff;
   logic [fpba_pkg::CountBits-1:0]  count_ff;
   logic                            rsp_valid_ff;
   fpba_pkg::rsp_type               rsp_item_ff;

   logic          accept;
   logic          req_go;
   logic          load_go;
   logic [8:0]    load_ext;
   logic [IW-1:0] load_idx;
   logic [SW-1:0] leftover;
   logic [SW-1:0] wr_data;
   logic [BLOCKS-1:0] wr_en;

   logic          chain_valid [BLOCKS+1];
   logic          chain_found [BLOCKS+1];
   logic [IW-1:0] chain_pick  [BLOCKS+1];
   logic [SW-1:0] chain_best  [BLOCKS+1];

   logic          end_valid;
   logic          end_found;
   logic [IW-1:0] end_pick;

   assign busy      = reset || (state_ff == ST_SCAN);
   assign accept    = start && !busy;
   assign req_go    = accept && (req_item.kind == fpba_pkg::KIND_REQUEST);
   assign load_ext  = {5'd0, req_item.block_index};
   assign load_go   = accept && (req_item.kind == fpba_pkg::KIND_LOAD)
                      && (load_ext < 9'(BLOCKS));
   assign load_idx  = IW'(load_ext);

   assign end_valid = chain_valid[BLOCKS];
   assign end_found = chain_found[BLOCKS];
   assign end_pick  = chain_pick[BLOCKS];
   assign leftover  = chain_best[BLOCKS] - amount_ff;
   assign wr_data   = end_valid ? leftover : SW'(req_item.amount);

   // head of the row: fresh transaction with no candidate yet
   assign chain_valid[0] = launch_ff;
   assign chain_found[0] = 1'b0;
   assign chain_pick[0]  = '0;
   assign chain_best[0]  = '0;

   for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
      logic cell_active;

      assign cell_active = (9'(i) < {4'd0, count_ff});
      // load at accept, or write back the winner at the end of the scan
      assign wr_en[i] = (load_go && (load_idx == IW'(i)))
                        || (end_valid && end_found && (end_pick == IW'(i)));

      fpba_cell #(
         .IW (IW),
         .SW (SW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IW'(i)),
         .active     (cell_active),
         .wr_en      (wr_en[i]),
         .wr_data    (wr_data),
         .amount     (amount_ff),
         .policy     (policy_ff),
         .prev_valid (chain_valid[i]),
         .prev_found (chain_found[i]),
         .prev_pick  (chain_pick[i]),
         .prev_best  (chain_best[i]),
         .cell_valid (chain_valid[i+1]),
         .cell_found (chain_found[i+1]),
         .cell_pick  (chain_pick[i+1]),
         .cell_best  (chain_best[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff    <= req_go;
         rsp_valid_ff <= end_valid;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_go) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (end_valid) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fpba_pkg::POLICY_RESET;
         count_ff  <= fpba_pkg::COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fpba_pkg::CSR_FIT_POLICY:    policy_ff <= csr_wdata[fpba_pkg::PolicyBits-1:0];
            fpba_pkg::CSR_BLOCKS_IN_USE: count_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         amount_ff <= SW'(req_item.amount);
      end
      if (end_valid) begin
         rsp_item_ff.granted       <= end_found;
         rsp_item_ff.chosen_block  <= end_found ? 4'(end_pick) : '0;
         rsp_item_ff.leftover_size <= end_found ? 16'(leftover) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   `ASSERT_ON_CLK(a_rsp_not_busy, clock, reset, rsp_valid |-> !busy)
   `ASSERT_ON_CLK(a_req_goes_busy, clock, reset, req_go |=> busy)
   `ASSERT_ON_CLK(a_scan_end_gives_rsp, clock, reset, end_valid |=> rsp_valid)
   `ASSERT_ON_CLK(a_refused_zero, clock, reset,
      (rsp_valid && !rsp_item.granted) |->
         ((rsp_item.chosen_block == '0) && (rsp_item.leftover_size == '0)))
   `ASSERT_ALWAYS(a_single_write, clock, reset || $onehot0(wr_en))

endmodule

// File: rtl/fpba_cell.sv
module fpba_cell #(
   parameter int IW = 4,
   parameter int SW = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [IW-1:0]                   cell_index,
   input  logic                            active,
   input  logic                            wr_en,
   input  logic [SW-1:0]                   wr_data,
   input  logic [SW-1:0]                   amount,
   input  logic [fpba_pkg::PolicyBits-1:0] policy,
   input  logic                            prev_valid,
   input  logic                            prev_found,
   input  logic [IW-1:0]                   prev_pick,
   input  logic [SW-1:0]                   prev_best,
   output logic                            cell_valid,
   output logic                            cell_found,
   output logic [IW-1:0]                   cell_pick,
   output logic [SW-1:0]                   cell_best
);

   logic [SW-1:0] size_ff;
   logic          valid_ff;
   logic          found_ff;
   logic [IW-1:0] pick_ff;
   logic [SW-1:0] best_ff;

   logic          fits;
   logic          take;
   logic          found_in;
   logic [IW-1:0] pick_in;
   logic [SW-1:0] best_in;

   always_comb begin
      fits = active && (size_ff >= amount);
      // first fit keeps the earliest candidate, the others keep comparing
      take = fits && (!prev_found
             || ((policy == fpba_pkg::POLICY_BEST) && (size_ff < prev_best))
             || ((policy == fpba_pkg::POLICY_WORST) && (size_ff > prev_best)));
      found_in = prev_found || fits;
      pick_in  = take ? cell_index : prev_pick;
      best_in  = take ? size_ff : prev_best;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         size_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pick_ff  <= pick_in;
      best_ff  <= best_in;
   end

   assign cell_valid = valid_ff;
   assign cell_found = found_ff;
   assign cell_pick  = pick_ff;
   assign cell_best  = best_ff;

endmodule
